>>> hdl/shpt_pkg.sv
// Shared types, constants and the hash word table for the string hash probe table.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package shpt_pkg;

    localparam int unsigned DefaultSlots = 16;
    localparam int unsigned CryptWordCount = 1280;
    localparam int unsigned CryptIdxW = $clog2(CryptWordCount);
    localparam logic [31:0] LcgInit = 32'h0010_0001;
    localparam logic [31:0] LcgMul = 32'd125;
    localparam logic [31:0] LcgMod = 32'h002A_AAAB;
    localparam logic [31:0] SeedOne = 32'h7FED_7FED;
    localparam logic [31:0] SeedTwo = 32'hEEEE_EEEE;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_FOUND = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_REMOVED = 3'd5;

    typedef logic [CryptWordCount-1:0][31:0] crypt_words_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] check_a;
        logic [31:0] check_b;
    } slot_entry_t;

    function automatic crypt_words_t build_crypt_words();
        crypt_words_t words;
        logic [31:0] lcg;
        logic [31:0] hi;
        logic [31:0] lo;
        words = '0;
        lcg = LcgInit;
        for (int row = 0; row < 256; row++)
        begin
            for (int k = 0; k < 5; k++)
            begin
                lcg = (lcg * LcgMul + 32'd3) % LcgMod;
                hi = {lcg[15:0], 16'h0000};
                lcg = (lcg * LcgMul + 32'd3) % LcgMod;
                lo = {16'h0000, lcg[15:0]};
                words[row + k * 256] = hi | lo;
            end
        end
        return words;
    endfunction

    localparam crypt_words_t CryptWords = build_crypt_words();

endpackage
`default_nettype wire

>>> hdl/shpt_mem.sv
// Slot memory: one write port, one registered read port.
// Depends on shpt_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none
module shpt_mem #(
    parameter int unsigned TABLE_SLOTS = shpt_pkg::DefaultSlots,
    localparam int unsigned IW = $clog2(TABLE_SLOTS)
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire [IW-1:0]              wr_addr,
    input  shpt_pkg::slot_entry_t     wr_data,
    input  wire [IW-1:0]              rd_addr,
    output shpt_pkg::slot_entry_t     rd_data
);

    shpt_pkg::slot_entry_t mem [TABLE_SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

>>> hdl/shpt_hash.sv
// Running seed pairs of the offset hash and the two check hashes.
// Depends on shpt_pkg for the word table and seed constants.
`timescale 1ns / 1ps
`default_nettype none
module shpt_hash (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        absorb,
    input  wire        restart,
    input  wire [7:0]  key_byte,
    output logic [31:0] off_next,
    output logic [31:0] ca_next,
    output logic [31:0] cb_next
);

    logic [31:0] s1_reg [3];
    logic [31:0] s2_reg [3];
    logic [31:0] s1_next [3];
    logic [31:0] s2_next [3];
    logic [7:0]  ch;

    always_comb
    begin
        ch = key_byte;
        if (key_byte >= 8'h61 && key_byte <= 8'h7A)
        begin
            ch = key_byte - 8'h20;
        end
        for (int t = 0; t < 3; t++)
        begin
            s1_next[t] = shpt_pkg::CryptWords[{1'b0, 2'(t), ch}]
                         ^ (s1_reg[t] + s2_reg[t]);
            s2_next[t] = {24'h0, ch} + s1_next[t] + s2_reg[t]
                         + {s2_reg[t][26:0], 5'b0} + 32'd3;
        end
    end

    assign off_next = s1_next[0];
    assign ca_next = s1_next[1];
    assign cb_next = s1_next[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < 3; t++)
            begin
                s1_reg[t] <= shpt_pkg::SeedOne;
                s2_reg[t] <= shpt_pkg::SeedTwo;
            end
        end
        else if (restart)
        begin
            for (int t = 0; t < 3; t++)
            begin
                s1_reg[t] <= shpt_pkg::SeedOne;
                s2_reg[t] <= shpt_pkg::SeedTwo;
            end
        end
        else if (absorb)
        begin
            for (int t = 0; t < 3; t++)
            begin
                s1_reg[t] <= s1_next[t];
                s2_reg[t] <= s2_next[t];
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/string_hash_probe_table.sv
// Top level: command port, probe sequencer and slot count of the string hash probe table.
// Depends on shpt_pkg, shpt_hash and shpt_mem.
//
//   channel  handshake       fields
//   input    start / busy    op, key_byte, last_byte, slot_to_free
//   result   done (strobe)   status, slot, occupancy
//
// A non-final key byte is absorbed in the idle state and leaves busy low.
// A final key byte probes up to TABLE_SLOTS slots via S_P_RD, S_P_CHK; remove via S_RM_CHK.
// After reset a clearing pass over every slot holds busy high.
// TABLE_SLOTS must be a power of 2, unchecked. Results last one cycle and cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module string_hash_probe_table #(
    parameter int unsigned TABLE_SLOTS = shpt_pkg::DefaultSlots
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    output logic       busy,
    input  wire [1:0]  op,
    input  wire [7:0]  key_byte,
    input  wire        last_byte,
    input  wire [3:0]  slot_to_free,
    output logic       done,
    output logic [2:0] status,
    output logic [3:0] slot,
    output logic [4:0] occupancy
);

    localparam int unsigned IW = $clog2(TABLE_SLOTS);
    localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
    localparam logic [IW-1:0] LastIdx = IW'(TABLE_SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RM_CHK,
        S_P_RD,
        S_P_CHK
    } state_t;

    state_t      state_reg;
    logic [IW-1:0] pos_reg;
    logic [IW-1:0] n_reg;
    logic        ins_reg;
    logic [31:0] ca_reg;
    logic [31:0] cb_reg;
    logic [CW-1:0] count_reg;
    logic        done_reg;
    logic [2:0]  status_reg;
    logic [3:0]  slot_reg;
    logic [4:0]  occ_reg;

    logic        accept;
    logic        key_op;
    logic        absorb;
    logic        restart;
    logic [31:0] off_next;
    logic [31:0] ca_next;
    logic [31:0] cb_next;
    logic [IW-1:0] free_pos;
    logic [IW-1:0] start_pos;
    logic        mem_we;
    logic [IW-1:0] mem_wr_addr;
    shpt_pkg::slot_entry_t mem_wr_data;
    logic [IW-1:0] mem_rd_addr;
    shpt_pkg::slot_entry_t mem_rd_data;
    logic        match;
    logic [IW+3:0] pos_wide;
    logic [CW+4:0] cnt_inc_wide;
    logic [CW+4:0] cnt_dec_wide;
    logic [CW+4:0] cnt_wide;

    assign accept = start && !busy;
    assign key_op = (op == shpt_pkg::OP_INSERT) || (op == shpt_pkg::OP_LOOKUP);
    assign absorb = accept && key_op;
    assign restart = absorb && last_byte;
    assign free_pos = IW'({{IW{1'b0}}, slot_to_free});
    assign start_pos = off_next[IW-1:0];
    assign pos_wide = {4'b0, pos_reg};
    assign cnt_wide = {5'b0, count_reg};
    assign cnt_inc_wide = {5'b0, count_reg + CW'(1)};
    assign cnt_dec_wide = {5'b0, count_reg - CW'(1)};
    assign match = (mem_rd_data.check_a == ca_reg) && (mem_rd_data.check_b == cb_reg);
    assign busy = (state_reg != S_IDLE);
    assign mem_rd_addr = (state_reg == S_IDLE) ? free_pos : pos_reg;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wr_addr = pos_reg;
        mem_wr_data = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_RM_CHK:
            begin
                mem_we = mem_rd_data.valid;
            end
            S_P_CHK:
            begin
                mem_we = ins_reg && !mem_rd_data.valid;
                mem_wr_data.valid = 1'b1;
                mem_wr_data.check_a = ca_reg;
                mem_wr_data.check_b = cb_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    shpt_hash u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .absorb   (absorb),
        .restart  (restart),
        .key_byte (key_byte),
        .off_next (off_next),
        .ca_next  (ca_next),
        .cb_next  (cb_next)
    );

    shpt_mem #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pos_reg <= '0;
            n_reg <= '0;
            ins_reg <= 1'b0;
            count_reg <= '0;
            done_reg <= 1'b0;
            status_reg <= shpt_pkg::ST_INSERTED;
            slot_reg <= '0;
            occ_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    pos_reg <= pos_reg + IW'(1);
                    if (pos_reg == LastIdx)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept && op == shpt_pkg::OP_REMOVE)
                    begin
                        pos_reg <= free_pos;
                        state_reg <= S_RM_CHK;
                    end
                    else if (restart)
                    begin
                        pos_reg <= start_pos;
                        n_reg <= '0;
                        ins_reg <= (op == shpt_pkg::OP_INSERT);
                        ca_reg <= ca_next;
                        cb_reg <= cb_next;
                        state_reg <= S_P_RD;
                    end
                end
                S_RM_CHK:
                begin
                    done_reg <= 1'b1;
                    status_reg <= shpt_pkg::ST_REMOVED;
                    slot_reg <= pos_wide[3:0];
                    if (mem_rd_data.valid)
                    begin
                        count_reg <= count_reg - CW'(1);
                        occ_reg <= cnt_dec_wide[4:0];
                    end
                    else
                    begin
                        occ_reg <= cnt_wide[4:0];
                    end
                    state_reg <= S_IDLE;
                end
                S_P_RD:
                begin
                    state_reg <= S_P_CHK;
                end
                S_P_CHK:
                begin
                    occ_reg <= cnt_wide[4:0];
                    slot_reg <= '0;
                    if (ins_reg && !mem_rd_data.valid)
                    begin
                        done_reg <= 1'b1;
                        status_reg <= shpt_pkg::ST_INSERTED;
                        slot_reg <= pos_wide[3:0];
                        count_reg <= count_reg + CW'(1);
                        occ_reg <= cnt_inc_wide[4:0];
                        state_reg <= S_IDLE;
                    end
                    else if (ins_reg && match)
                    begin
                        done_reg <= 1'b1;
                        status_reg <= shpt_pkg::ST_DUPLICATE;
                        state_reg <= S_IDLE;
                    end
                    else if (!ins_reg && mem_rd_data.valid && match)
                    begin
                        done_reg <= 1'b1;
                        status_reg <= shpt_pkg::ST_FOUND;
                        slot_reg <= pos_wide[3:0];
                        state_reg <= S_IDLE;
                    end
                    else if (n_reg == LastIdx)
                    begin
                        done_reg <= 1'b1;
                        status_reg <= ins_reg ? shpt_pkg::ST_FULL : shpt_pkg::ST_NOT_FOUND;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + IW'(1);
                        n_reg <= n_reg + IW'(1);
                        state_reg <= S_P_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign status = status_reg;
    assign slot = slot_reg;
    assign occupancy = occ_reg;

endmodule
`default_nettype wire
